FILE: rtl/lfms_pkg.sv
// Shared types, request and status codes, and defaults for the multi-stack bank.
package lfms_pkg;

    localparam int NUM_STACKS_DEF   = 16;
    localparam int MAX_CAPACITY_DEF = 16;

    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // register index decoded from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_POP     = 2'd1;
    localparam logic [1:0] REQ_POP_IDX = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] push_value;
        logic [15:0]        stack_index;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic latch_req;
        logic exec;
        logic load_out;
    } cmd_t;

endpackage

FILE: rtl/leftmost_free_multi_stack.sv
// Top level of the multi-stack bank: ports, capacity register, controller and datapath.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  in_word  (req_type, push_value, stack_index)
//  out       output     out_valid/out_stall  out_word (pop_value, status)
//  cfg       input      APB psel/penable     stack_capacity at byte address 0
//
// Each word passes through accept, an update step that searches the fill
// counts and does the single value-store access, then the result register load.
// The next word is accepted while a result still waits downstream.
// Reset clears fill counts and the stack count at once; no clearing pass.
// The value store is never cleared. A stalled result holds the bank in its last step.
module leftmost_free_multi_stack #(
    parameter int NUM_STACKS   = lfms_pkg::NUM_STACKS_DEF,
    parameter int MAX_CAPACITY = lfms_pkg::MAX_CAPACITY_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lfms_pkg::req_t in_word,
    output logic           out_valid,
    input  logic           out_stall,
    output lfms_pkg::rsp_t out_word,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [lfms_pkg::CAP_W-1:0] cap_reg;
    logic                       cap_we;
    lfms_pkg::cmd_t             cmd;

    assign pready = 1'b1;
    assign cap_we = psel && penable && pwrite && (paddr[2] == lfms_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == lfms_pkg::REG_CAPACITY) ? 32'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lfms_pkg::CAP_RESET;
        else if (cap_we)
            cap_reg <= pwdata[lfms_pkg::CAP_W-1:0];
    end

    lfms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lfms_dp #(
        .NUM_STACKS   (NUM_STACKS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_word        (in_word),
        .stack_capacity (cap_reg),
        .out_word       (out_word)
    );

endmodule

FILE: rtl/lfms_ctrl.sv
// Sequencer for the multi-stack bank: accept, update, result handoff.
module lfms_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output lfms_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   load;

    assign accept   = in_valid && (state_reg == S_IDLE);
    // result register is free, or its word leaves this cycle
    assign load     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.latch_req = accept;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.load_out  = load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/lfms_dp.sv
// Datapath: fill counts, stacks-in-use count, value store and result register.
module lfms_dp #(
    parameter int NUM_STACKS   = lfms_pkg::NUM_STACKS_DEF,
    parameter int MAX_CAPACITY = lfms_pkg::MAX_CAPACITY_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfms_pkg::cmd_t            cmd,
    input  lfms_pkg::req_t            in_word,
    input  logic [lfms_pkg::CAP_W-1:0] stack_capacity,
    output lfms_pkg::rsp_t            out_word
);

    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int UW    = $clog2(NUM_STACKS + 1);
    localparam int FW    = $clog2(MAX_CAPACITY + 1);
    localparam int CW    = (FW > lfms_pkg::CAP_W) ? FW : lfms_pkg::CAP_W;
    localparam int DEPTH = NUM_STACKS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lfms_pkg::req_t req_reg;
    lfms_pkg::rsp_t out_word_reg;
    logic [FW-1:0]  fill_reg [NUM_STACKS];
    logic [UW-1:0]  in_use_reg;
    logic [1:0]     res_status_reg;
    logic           pop_ok_reg;
    logic [31:0]    rd_data_reg;
    logic [31:0]    mem [DEPTH];

    logic [CW-1:0]         eff_cap;
    logic [NUM_STACKS-1:0] full_vec;
    logic [NUM_STACKS-1:0] nonempty_vec;
    logic [NUM_STACKS-1:0] live_vec;
    logic [NUM_STACKS-1:0] cand_vec;
    logic [NUM_STACKS-1:0] ne_after;
    logic [SW-1:0]         first_free;
    logic                  has_free;
    logic [SW-1:0]         tgt;
    logic                  do_push;
    logic                  do_pop;
    logic                  grow;
    logic [1:0]            status;
    logic [FW-1:0]         fill_tgt;
    logic [FW-1:0]         fill_dec;
    logic [FW-1:0]         fill_inc;
    logic [AW-1:0]         mem_addr;
    logic [UW-1:0]         trim_use;
    logic                  mem_we;
    logic                  mem_re;

    always_comb
    begin
        if (stack_capacity == '0)
            eff_cap = CW'(1);
        else if (CW'(stack_capacity) > CW'(MAX_CAPACITY))
            eff_cap = CW'(MAX_CAPACITY);
        else
            eff_cap = CW'(stack_capacity);

        for (int s = 0; s < NUM_STACKS; s++)
        begin
            full_vec[s]     = (CW'(fill_reg[s]) >= eff_cap);
            nonempty_vec[s] = (fill_reg[s] != '0);
            live_vec[s]     = (UW'(s) < in_use_reg);
        end
        cand_vec = live_vec & ~full_vec;

        // leftmost non-full stack in use
        first_free = '0;
        has_free   = 1'b0;
        for (int s = NUM_STACKS - 1; s >= 0; s--)
        begin
            if (cand_vec[s])
            begin
                first_free = SW'(s);
                has_free   = 1'b1;
            end
        end
    end

    always_comb
    begin
        tgt     = '0;
        do_push = 1'b0;
        do_pop  = 1'b0;
        grow    = 1'b0;
        status  = lfms_pkg::ST_DONE;
        unique case (req_reg.req_type)
            lfms_pkg::REQ_PUSH:
            begin
                if (has_free)
                begin
                    tgt     = first_free;
                    do_push = 1'b1;
                end
                else if (in_use_reg < UW'(NUM_STACKS))
                begin
                    tgt     = SW'(in_use_reg);
                    grow    = 1'b1;
                    do_push = 1'b1;
                end
                else
                    status = lfms_pkg::ST_FULL;
            end
            lfms_pkg::REQ_POP:
            begin
                if (in_use_reg == '0)
                    status = lfms_pkg::ST_EMPTY;
                else
                begin
                    tgt    = SW'(in_use_reg - 1'b1);
                    do_pop = 1'b1;
                end
            end
            lfms_pkg::REQ_POP_IDX:
            begin
                if (req_reg.stack_index >= 16'(in_use_reg))
                    status = lfms_pkg::ST_EMPTY;
                else if (fill_reg[SW'(req_reg.stack_index)] == '0)
                    status = lfms_pkg::ST_EMPTY;
                else
                begin
                    tgt    = SW'(req_reg.stack_index);
                    do_pop = 1'b1;
                end
            end
            default:
            begin
                status = lfms_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        fill_tgt = fill_reg[tgt];
        fill_dec = fill_tgt - 1'b1;
        fill_inc = fill_tgt + 1'b1;
        mem_addr = AW'(tgt) * AW'(MAX_CAPACITY) + AW'(do_pop ? fill_dec : fill_tgt);

        // trailing-empty trim: new count is one past the highest non-empty stack
        ne_after      = nonempty_vec;
        ne_after[tgt] = (fill_dec != '0);
        trim_use      = '0;
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            if (ne_after[s])
                trim_use = UW'(s + 1);
        end
    end

    assign mem_we = cmd.exec && do_push;
    assign mem_re = cmd.exec && do_pop;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= req_reg.push_value;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
            req_reg <= in_word;
        if (cmd.exec)
        begin
            res_status_reg <= status;
            pop_ok_reg     <= do_pop;
        end
        if (cmd.load_out)
        begin
            out_word_reg.pop_value <= pop_ok_reg ? rd_data_reg : '0;
            out_word_reg.status    <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STACKS; s++)
                fill_reg[s] <= '0;
            in_use_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (do_push)
            begin
                fill_reg[tgt] <= fill_inc;
                if (grow)
                    in_use_reg <= in_use_reg + 1'b1;
            end
            else if (do_pop)
            begin
                fill_reg[tgt] <= fill_dec;
                in_use_reg    <= trim_use;
            end
        end
    end

    assign out_word = out_word_reg;

    a_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= UW'(NUM_STACKS))
        else $error("stack count beyond bank size");

    a_tail_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_use_reg != '0) |-> (fill_reg[SW'(in_use_reg - 1'b1)] != '0))
        else $error("rightmost stack in use is empty");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("value store written and read together");

    a_grow_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_use_reg != $past(in_use_reg) && $past(rst_n)) |-> $past(cmd.exec))
        else $error("stack count changed outside an update");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the leftmost-free multi-stack bank.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         NSTK       = lfms_pkg::NUM_STACKS_DEF;
    localparam int         MAX_CAP    = lfms_pkg::MAX_CAPACITY_DEF;
    localparam logic [2:0] CAP_ADDR   = {lfms_pkg::REG_CAPACITY, 2'b00};
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    lfms_pkg::req_t in_word;
    logic           out_valid;
    logic           out_stall = 1'b0;
    lfms_pkg::rsp_t out_word;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    // predicted bank contents
    int          fill [NSTK];
    logic [31:0] plate [NSTK][MAX_CAP];
    int          used;
    logic [4:0]  cap_reg;

    lfms_pkg::rsp_t owed_results [$];
    int   err_count;
    int   n_push, n_drop, n_pop_ok, n_empty, n_ignored, n_cfg;

    // sender burst state and receiver stall pattern
    int   burst_left;
    bit   gaps_on;
    int   stall_tick;
    int   stall_mode;

    leftmost_free_multi_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // remove the top of stack s, then drop empty stacks off the right end
    function automatic logic [31:0] pop_stack(int s);
        fill[s]--;
        pop_stack = plate[s][fill[s]];
        while (used > 0 && fill[used - 1] == 0)
            used--;
    endfunction

    function automatic lfms_pkg::rsp_t bank_apply(lfms_pkg::req_t w);
        lfms_pkg::rsp_t r;
        int   cap;
        int   tgt;
        bit   hit;
        r.pop_value = '0;
        r.status    = lfms_pkg::ST_DONE;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > MAX_CAP) ? MAX_CAP : int'(cap_reg));
        case (w.req_type)
            lfms_pkg::REQ_PUSH:
            begin
                hit = 1'b0;
                tgt = 0;
                for (int s = 0; s < used; s++)
                    if (!hit && fill[s] < cap)
                    begin
                        tgt = s;
                        hit = 1'b1;
                    end
                if (!hit && used < NSTK)
                begin
                    tgt = used;
                    used++;
                    hit = 1'b1;
                end
                if (hit)
                begin
                    plate[tgt][fill[tgt]] = w.push_value;
                    fill[tgt]++;
                end
                else
                    r.status = lfms_pkg::ST_FULL;
            end
            lfms_pkg::REQ_POP:
            begin
                if (used == 0)
                    r.status = lfms_pkg::ST_EMPTY;
                else
                    r.pop_value = pop_stack(used - 1);
            end
            lfms_pkg::REQ_POP_IDX:
            begin
                if (w.stack_index >= used || fill[w.stack_index] == 0)
                    r.status = lfms_pkg::ST_EMPTY;
                else
                    r.pop_value = pop_stack(int'(w.stack_index));
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic lfms_pkg::req_t make_req(logic [1:0] op, logic [31:0] val,
                                                logic [15:0] idx);
        lfms_pkg::req_t w;
        w.req_type    = op;
        w.push_value  = val;
        w.stack_index = idx;
        return w;
    endfunction

    task automatic idle_sender(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // present one word, wait for it to be taken, and log what it should produce
    task automatic send_req(lfms_pkg::req_t w);
        lfms_pkg::rsp_t r;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        r = bank_apply(w);
        owed_results.insert(owed_results.size(), r);
        if (w.req_type == REQ_UNUSED)
            n_ignored++;
        else if (w.req_type == lfms_pkg::REQ_PUSH)
        begin
            if (r.status == lfms_pkg::ST_FULL) n_drop++;
            else n_push++;
        end
        else if (r.status == lfms_pkg::ST_EMPTY)
            n_empty++;
        else
            n_pop_ok++;
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                idle_sender($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic settle_bank();
        idle_sender(1);
        while (owed_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write the capacity register, then read it back
    task automatic cfg_write(logic [4:0] value);
        logic [31:0] wd;
        wd = {27'($urandom_range(0, 32'h07FF_FFFF)), value};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= wd;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cap_reg = value;
        n_cfg++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {27'b0, value})
            report_mismatch($sformatf("capacity readback %0h, wrote %0d", prdata, value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_bank();
        send_req(make_req(lfms_pkg::REQ_POP, 32'h0, 16'h0));
        send_req(make_req(lfms_pkg::REQ_POP_IDX, 32'h0, 16'h0));
        send_req(make_req(lfms_pkg::REQ_POP_IDX, 32'hFFFF_FFFF, 16'hFFFF));
        send_req(make_req(REQ_UNUSED, 32'h1234_5678, 16'h0001));
        settle_bank();
    endtask

    // one value per stack, so the bank fills after NSTK pushes
    task automatic test_full_bank();
        logic [31:0] v;
        cfg_write(5'd1);
        for (int i = 0; i < NSTK; i++)
        begin
            case (i)
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                3: v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            send_req(make_req(lfms_pkg::REQ_PUSH, v, 16'h0));
        end
        send_req(make_req(lfms_pkg::REQ_PUSH, 32'h5A5A_A5A5, 16'h0));
        settle_bank();
    endtask

    // hole in the middle, refilled by the next push
    task automatic test_indexed_pop();
        send_req(make_req(lfms_pkg::REQ_POP_IDX, 32'h0, 16'd5));
        send_req(make_req(lfms_pkg::REQ_POP_IDX, 32'h0, 16'd5));
        send_req(make_req(lfms_pkg::REQ_POP, 32'h0, 16'h0));
        send_req(make_req(lfms_pkg::REQ_PUSH, 32'hC001_D00D, 16'h0));
        settle_bank();
    endtask

    task automatic run_phase(logic [4:0] cap, int n_items, int push_pct, bit gaps);
        lfms_pkg::req_t w;
        int          r;
        int          done;
        logic [31:0] v;
        logic [15:0] idx;
        cfg_write(cap);
        gaps_on    = gaps;
        burst_left = $urandom_range(1, 24);
        done       = 0;
        while (done < n_items)
        begin
            r = $urandom_range(0, 99);
            v = $urandom;
            if ($urandom_range(0, 9) == 0)
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0;
                    default: v = 32'hFFFF_FFFF;
                endcase
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7)
                idx = 16'($urandom_range(0, used));
            else if ($urandom_range(0, 2) != 0)
                idx = 16'($urandom_range(0, NSTK));
            else
                idx = 16'($urandom_range(0, 16'hFFFF));
            if (r < push_pct)
                w = make_req(lfms_pkg::REQ_PUSH, v, idx);
            else if ($urandom_range(0, 19) == 0)
                w = make_req(REQ_UNUSED, v, idx);
            else if ($urandom_range(0, 1) == 0)
                w = make_req(lfms_pkg::REQ_POP, v, idx);
            else
                w = make_req(lfms_pkg::REQ_POP_IDX, v, idx);
            send_req(w);
            if (w.req_type != REQ_UNUSED)
                done++;
        end
        gaps_on = 1'b0;
        settle_bank();
    endtask

    task automatic test_random_mix();
        run_phase(5'd16, 180, 75, 1'b1);
        run_phase(5'd3,  100, 55, 1'b1);   // lowered under fuller stacks
        run_phase(5'd0,  100, 50, 1'b0);
        run_phase(5'd31, 120, 70, 1'b1);
        run_phase(5'd1,  100, 60, 1'b1);
        run_phase(5'd16, 150, 30, 1'b1);
        run_phase(5'd2,  100, 65, 1'b0);
        run_phase(5'd17, 100, 50, 1'b1);
        run_phase(5'd7,  100, 60, 1'b1);
        run_phase(5'd16,  75, 50, 1'b1);
    endtask

    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((stall_tick % 11) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        lfms_pkg::rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result with nothing pending: value %0h status %0d",
                                          out_word.pop_value, out_word.status));
            else
            begin
                want = owed_results.pop_front();
                if (out_word.pop_value !== want.pop_value)
                    report_mismatch($sformatf("pop_value %0h, predicted %0h",
                                              out_word.pop_value, want.pop_value));
                if (out_word.status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              out_word.status, want.status));
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", owed_results.size());
        $display("leftmost_free_multi_stack regression: fail");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        used       = 0;
        cap_reg    = lfms_pkg::CAP_RESET;
        gaps_on    = 1'b0;
        burst_left = 1;
        stall_tick = 0;
        stall_mode = 0;
        err_count  = 0;
        n_push = 0; n_drop = 0; n_pop_ok = 0; n_empty = 0; n_ignored = 0; n_cfg = 0;
        for (int s = 0; s < NSTK; s++)
            fill[s] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_bank();
        test_full_bank();
        test_indexed_pop();
        test_random_mix();

        while (owed_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d pushes, %0d dropped pushes, %0d pops, %0d empty pops, %0d ignored",
                 n_push, n_drop, n_pop_ok, n_empty, n_ignored);
        $display("across %0d capacity settings, %0d mismatches", n_cfg, err_count);
        if (err_count == 0)
            $display("leftmost_free_multi_stack regression: pass");
        else
            $display("leftmost_free_multi_stack regression: fail");
        $finish;
    end

endmodule
